/* design/exchange_sort_buffer_macros.svh */
// Assertion macros for the exchange sort buffer.
`ifndef EXCHANGE_SORT_BUFFER_MACROS_SVH
`define EXCHANGE_SORT_BUFFER_MACROS_SVH

`ifndef SYNTHESIS

// Implication-style property, disabled during reset.
`define ESB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("esb assertion failed");

// Condition that must never be true outside reset.
`define ESB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("esb forbidden condition seen");

`else

`define ESB_ASSERT(lbl, clk, rst_n, prop)

`define ESB_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* design/esb_pkg.sv */
// Shared types and constants for the exchange sort buffer.
package esb_pkg;

    localparam int ESB_WORD_BITS = 32;

    typedef struct packed {
        logic [ESB_WORD_BITS-1:0] data_word;
        logic                     last_word;
    } t_in_item;

    typedef struct packed {
        logic [ESB_WORD_BITS-1:0] sorted_word;
        logic                     last_sorted;
        logic                     overflow;
    } t_out_item;

    typedef struct packed {
        logic we;
        logic re;
    } t_ram_ctl;

    typedef struct packed {
        logic load;
        logic last;
        logic overflow;
    } t_out_ctl;

endpackage

/* design/esb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module esb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/esb_ctrl.sv */
// Sequencer for load, exchange sort passes and readout of the word store.
module esb_ctrl import esb_pkg::*; #(
    parameter int MAX_WORDS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  t_in_item                     i_in_data,
    output logic                         o_in_stall,
    input  logic                         i_out_free,
    input  logic [ESB_WORD_BITS-1:0]     i_rd_data,
    output t_ram_ctl                     o_ram,
    output logic [$clog2(MAX_WORDS)-1:0] o_waddr,
    output logic [ESB_WORD_BITS-1:0]     o_wdata,
    output logic [$clog2(MAX_WORDS)-1:0] o_raddr,
    output t_out_ctl                     o_out
);

    localparam int ADDR_W = $clog2(MAX_WORDS);
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WORDS);

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_PIV  = 5'b00010,
        S_SCAN = 5'b00100,
        S_ORD  = 5'b01000,
        S_OCAP = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_flag, n_flag;
    logic                     r_first, n_first;
    logic                     r_pend, n_pend;
    logic [ADDR_W-1:0]        r_i, n_i;
    logic [CNT_W-1:0]         r_j, n_j;
    logic [ADDR_W-1:0]        r_pj, n_pj;
    logic [ADDR_W-1:0]        r_k, n_k;
    logic [ESB_WORD_BITS-1:0] r_pivot, n_pivot;
    logic [ADDR_W-1:0]        last_idx;
    logic [CNT_W-1:0]         count_m1;

    assign count_m1 = r_count - CNT_W'(1);
    assign last_idx = count_m1[ADDR_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_flag   = r_flag;
        n_first  = r_first;
        n_pend   = r_pend;
        n_i      = r_i;
        n_j      = r_j;
        n_pj     = r_pj;
        n_k      = r_k;
        n_pivot  = r_pivot;
        o_ram    = '0;
        o_out    = '0;
        o_waddr  = r_pj;
        o_wdata  = r_pivot;
        o_raddr  = r_j[ADDR_W-1:0];

        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (r_count < MAX_CNT) begin
                        o_ram.we = 1'b1;
                        o_waddr  = r_count[ADDR_W-1:0];
                        o_wdata  = i_in_data.data_word;
                        n_count  = r_count + CNT_W'(1);
                    end else begin
                        n_flag = 1'b1;
                    end
                    if (i_in_data.last_word) begin
                        n_i     = '0;
                        n_state = S_PIV;
                    end
                end
            end
            S_PIV: begin
                // fetch pivot element i
                o_ram.re = 1'b1;
                o_raddr  = r_i;
                n_j      = '0;
                n_first  = 1'b1;
                n_pend   = 1'b0;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                if (r_j < r_count) begin
                    o_ram.re = 1'b1;
                    o_raddr  = r_j[ADDR_W-1:0];
                    n_pend   = 1'b1;
                    n_pj     = r_j[ADDR_W-1:0];
                    n_j      = r_j + CNT_W'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_first) begin
                    n_pivot = i_rd_data;
                    n_first = 1'b0;
                end else if (r_pend) begin
                    // entry i in memory is stale while the pivot is live: skip it
                    if (r_pj != r_i && r_pivot < i_rd_data) begin
                        o_ram.we = 1'b1;
                        o_waddr  = r_pj;
                        o_wdata  = r_pivot;
                        n_pivot  = i_rd_data;
                    end
                end else begin
                    // pass drained: write pivot back to slot i
                    o_ram.we = 1'b1;
                    o_waddr  = r_i;
                    o_wdata  = r_pivot;
                    if (r_i == last_idx) begin
                        n_k     = '0;
                        n_state = S_ORD;
                    end else begin
                        n_i     = r_i + ADDR_W'(1);
                        n_state = S_PIV;
                    end
                end
            end
            S_ORD: begin
                o_raddr = r_k;
                if (i_out_free) begin
                    o_ram.re = 1'b1;
                    n_state  = S_OCAP;
                end
            end
            S_OCAP: begin
                o_out.load     = 1'b1;
                o_out.last     = (r_k == last_idx);
                o_out.overflow = r_flag;
                if (r_k == last_idx) begin
                    n_count = '0;
                    n_flag  = 1'b0;
                    n_state = S_LOAD;
                end else begin
                    n_k     = r_k + ADDR_W'(1);
                    n_state = S_ORD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_flag  <= 1'b0;
            r_first <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_flag  <= n_flag;
            r_first <= n_first;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_pj    <= n_pj;
        r_k     <= n_k;
        r_pivot <= n_pivot;
    end

endmodule

/* design/exchange_sort_buffer.sv */
// Top level of the exchange sort buffer: word store, sequencer, output register.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one word per
// transaction, one per cycle while loading. A transaction with last_word set
// closes the set. Up to MAX_WORDS words are kept; later words of the same set
// are dropped and every result of that set then carries overflow.
// After the closing transaction the input stalls while the store is sorted in
// place: for each slot i the pivot is held in a register and every other slot
// is streamed through one RAM read port, swapping through the write port.
// Each pass streams all n stored words through the single RAM port pair.
// Readout then takes each word through a RAM read and an output register load.
// A stall on the output channel holds the output register and pauses readout.
// The input reopens once the last result sits in the output register, so the
// next set can start while that result still waits to be taken.
// Reset clears the count, the overflow flag and the output valid; the store
// itself is not cleared.
`include "exchange_sort_buffer_macros.svh"

module exchange_sort_buffer import esb_pkg::*; #(
    parameter int MAX_WORDS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int ADDR_W = $clog2(MAX_WORDS);

    t_ram_ctl                 ram_ctl;
    t_out_ctl                 out_ctl;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [ESB_WORD_BITS-1:0] ram_wdata;
    logic [ESB_WORD_BITS-1:0] ram_rdata;
    logic                     out_free;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data, n_out_data;

    // register is free if empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    esb_ram #(
        .WIDTH (ESB_WORD_BITS),
        .DEPTH (MAX_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_ctl.we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_ctl.re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    esb_ctrl #(
        .MAX_WORDS (MAX_WORDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .i_rd_data  (ram_rdata),
        .o_ram      (ram_ctl),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_raddr    (ram_raddr),
        .o_out      (out_ctl)
    );

    // Output register: loaded from RAM read data, cleared when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (out_ctl.load) begin
            n_out_valid            = 1'b1;
            n_out_data.sorted_word = ram_rdata;
            n_out_data.last_sorted = out_ctl.last;
            n_out_data.overflow    = out_ctl.overflow;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The sequencer only loads the output register once it has been emptied.
    `ESB_ASSERT_NEVER(a_load_into_full, i_clk, i_rst_n, out_ctl.load && r_out_valid)

    // No RAM read may be issued while an input transaction is being stored.
    `ESB_ASSERT_NEVER(a_no_read_on_load, i_clk, i_rst_n,
                      i_in_valid && !o_in_stall && ram_ctl.re)

    // Loading the final result reopens the input channel in the next cycle.
    `ESB_ASSERT(a_reopen_after_last, i_clk, i_rst_n,
                (out_ctl.load && out_ctl.last) |=> !o_in_stall)

    // Output data holds while a valid result is stalled.
    `ESB_ASSERT(a_out_hold, i_clk, i_rst_n,
                (r_out_valid && i_out_stall) |=> $stable(o_out_data))

endmodule

/* tb/sv/exchange_sort_buffer_test.sv */
// Self-checking testbench for the exchange sort buffer: sets in, sorted runs out.
module exchange_sort_buffer_test;
    import esb_pkg::*;

    localparam int MAX_WORDS  = 64;
    localparam int HALF       = 5;
    localparam int RST_CYCLES = 4;
    // Watchdog bound, well above the slowest legal run (full sets, plus stalls).
    localparam int LIMIT      = 200000;
    localparam int TAIL       = 20;
    localparam int RAND_ITEMS = 24;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    // Words of the set being collected, and whether any were dropped.
    logic [ESB_WORD_BITS-1:0] set_words[$];
    logic                     set_dropped = 1'b0;
    // Sorted results still owed by the block, oldest first.
    t_out_item                pending_sorted[$];
    t_out_item                want;

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    // Receiver wait before the next result, and a one-shot long hold.
    int  rx_wait        = 0;
    int  hold_len       = 0;
    // No idling on either side while set.
    bit  steady         = 1'b0;

    exchange_sort_buffer #(
        .MAX_WORDS(MAX_WORDS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #(HALF) clk = ~clk;

    // Predictor: store or drop each word; a closing word sorts the set and
    // queues one result per stored word.
    function automatic void collect_word(t_in_item item);
        logic [ESB_WORD_BITS-1:0] key;
        int                       b;
        t_out_item                res;
        if (set_words.size() < MAX_WORDS) begin
            set_words.push_back(item.data_word);
        end else begin
            set_dropped = 1'b1;
        end
        if (item.last_word) begin
            for (int a = 1; a < set_words.size(); a++) begin
                key = set_words[a];
                b   = a;
                while (b > 0 && set_words[b-1] > key) begin
                    set_words[b] = set_words[b-1];
                    b--;
                end
                set_words[b] = key;
            end
            for (int k = 0; k < set_words.size(); k++) begin
                res.sorted_word = set_words[k];
                res.last_sorted = (k == set_words.size() - 1);
                res.overflow    = set_dropped;
                pending_sorted.push_back(res);
            end
            set_words.delete();
            set_dropped = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [ESB_WORD_BITS-1:0] exp_v,
                                   input logic [ESB_WORD_BITS-1:0] got_v);
        $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, exp_v, got_v);
        mismatch_count++;
    endtask

    // Both channels are sampled at the falling edge: the values seen there are
    // the ones the next rising edge acts on, so a transaction seen here
    // completes at that edge.
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && in_stall === 1'b0) begin
                collect_word(in_data);
            end
            if (out_valid === 1'b1 && !out_stall) begin
                if (pending_sorted.size() == 0) begin
                    report_mismatch("unexpected result, word", '0, out_data.sorted_word);
                end else begin
                    want = pending_sorted.pop_front();
                    if (out_data.sorted_word !== want.sorted_word) begin
                        report_mismatch("sorted_word", want.sorted_word, out_data.sorted_word);
                    end
                    if (out_data.last_sorted !== want.last_sorted) begin
                        report_mismatch("last_sorted", ESB_WORD_BITS'(want.last_sorted),
                                        ESB_WORD_BITS'(out_data.last_sorted));
                    end
                    if (out_data.overflow !== want.overflow) begin
                        report_mismatch("overflow", ESB_WORD_BITS'(want.overflow),
                                        ESB_WORD_BITS'(out_data.overflow));
                    end
                end
                // Draw the receiver's wait before it takes the next result.
                if (hold_len > 0) begin
                    rx_wait  = hold_len;
                    hold_len = 0;
                end else begin
                    rx_wait = steady ? 0 : $urandom_range(0, 9);
                end
            end
        end
    end

    // Receiver: stall for the drawn number of cycles after each transaction.
    always @(posedge clk) begin
        if (rx_wait > 0) begin
            out_stall <= 1'b1;
            rx_wait    = rx_wait - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Offers one word and returns at the rising edge that takes it. Valid is
    // left high so back-to-back words need no extra edge.
    task automatic send_word(input logic [ESB_WORD_BITS-1:0] w, input logic lst);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_data.data_word <= w;
        in_data.last_word <= lst;
        @(negedge clk);
        while (in_stall !== 1'b0) @(negedge clk);
        @(posedge clk);
    endtask

    // Mix of extremes, single-bit patterns, small values for duplicates.
    function automatic logic [ESB_WORD_BITS-1:0] pick_word();
        logic [ESB_WORD_BITS-1:0] one_bit;
        one_bit = 1 << $urandom_range(0, ESB_WORD_BITS - 1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 15);
            3:       return one_bit;
            4:       return ~one_bit;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short sets; now and then one near or past capacity.
    function automatic int pick_set_size();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16) return $urandom_range(1, 8);
        if (r < 19) return $urandom_range(9, 40);
        return $urandom_range(MAX_WORDS - 2, MAX_WORDS + 4);
    endfunction

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++) begin
            send_word(pick_word(), k == n - 1);
        end
    endtask

    // Valid drops first so the last word is not offered again.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    // One-word sets at both ends of the range.
    task automatic test_single_word_sets();
        send_word('0, 1'b1);
        send_word('1, 1'b1);
    endtask

    // Reverse order, sorted order, all equal, and extremes with duplicates.
    task automatic test_ordering();
        send_word(32'd5, 1'b0);
        send_word(32'd4, 1'b0);
        send_word(32'd3, 1'b0);
        send_word(32'd2, 1'b0);
        send_word(32'd1, 1'b1);
        send_word(32'd1, 1'b0);
        send_word(32'd2, 1'b0);
        send_word(32'd3, 1'b1);
        send_word(32'hA5A5_A5A5, 1'b0);
        send_word(32'hA5A5_A5A5, 1'b0);
        send_word(32'hA5A5_A5A5, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
    endtask

    // Store filled exactly, then the closing word dropped.
    // Runs with no idling on either side.
    task automatic test_capacity();
        steady = 1'b1;
        send_set(MAX_WORDS + 1);
        steady = 1'b0;
    endtask

    // Receiver holds off for a long stretch after the first result while the
    // sender keeps offering the next set, so readout stops and input stalls.
    task automatic test_back_pressure();
        drain();
        hold_len = 300;
        steady   = 1'b1;
        send_set(6);
        send_set(5);
        steady   = 1'b0;
    endtask

    task automatic test_random_sets();
        int sent;
        int n;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            n      = pick_set_size();
            steady = ($urandom_range(0, 5) == 0);
            send_set(n);
            sent  += n;
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_word_sets();
        test_ordering();
        test_capacity();
        test_back_pressure();
        test_random_sets();
        drain();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/esb_pkg.sv
design/esb_ram.sv
design/esb_ctrl.sv
design/exchange_sort_buffer.sv
tb/sv/exchange_sort_buffer_test.sv
